// File: hdl/dtfsn_pkg.sv
// ----------------------------------------------------------------------------
// dtfsn_pkg: shared types and constants
// Holds the binary64 field constants and the stage payload structs.
// ----------------------------------------------------------------------------
package dtfsn_pkg;

   localparam int unsigned D_EXP_W  = 11;
   localparam int unsigned D_FRAC_W = 52;

   // Stage 1 -> stage 2: operand classification and raw rounding inputs.
   typedef struct packed {
      logic                reject;     // NaN operand, value too large or equal operands
      logic                down;       // target lies below value
      logic                v_sign;
      logic                v_zero;     // value is +0 or -0
      logic [D_EXP_W-1:0]  v_exp;
      logic [D_FRAC_W-1:0] v_frac;
   } s1_type;

   // Stage 2 -> stage 3: rounded float and exactness.
   typedef struct packed {
      logic        reject;
      logic        down;
      logic        sign;
      logic        exact;      // rounding lost nothing
      logic        rnd_up;     // rounded magnitude above the value's magnitude
      logic [30:0] mag;        // rounded magnitude (may reach infinity code)
   } s2_type;

endpackage

// File: hdl/dtfsn_classify.sv
// ----------------------------------------------------------------------------
// dtfsn_classify: operand checks
// Flags NaN, out-of-range values and equal operands, and finds direction.
// ----------------------------------------------------------------------------
module dtfsn_classify
   import dtfsn_pkg::*;
(
   input  logic [63:0] value_bits,
   input  logic [63:0] toward_bits,
   output s1_type      s1
);
   // FLT_MAX as binary64 magnitude
   localparam logic [62:0] FMAX_D = 63'h47EF_FFFF_E000_0000;
   localparam logic [62:0] INF_D  = 63'h7FF0_0000_0000_0000;

   logic [62:0] vm, tm;
   logic        vs, ts, v_nan, t_nan, v_big, v_z, t_z, eq, v_lt_t;

   always_comb begin
      vm    = value_bits[62:0];
      tm    = toward_bits[62:0];
      vs    = value_bits[63];
      ts    = toward_bits[63];
      v_nan = vm > INF_D;
      t_nan = tm > INF_D;
      v_big = vm > FMAX_D;
      v_z   = vm == 63'd0;
      t_z   = tm == 63'd0;
      eq    = (v_z && t_z) || (value_bits == toward_bits);
      // signed-magnitude compare for v < t
      if (v_z && t_z)
         v_lt_t = 1'b0;
      else if (vs != ts)
         v_lt_t = vs;
      else if (!vs)
         v_lt_t = vm < tm;
      else
         v_lt_t = vm > tm;
      s1.reject = v_nan || t_nan || v_big || eq;
      s1.down   = !v_lt_t;
      s1.v_sign = vs;
      s1.v_zero = v_z;
      s1.v_exp  = value_bits[62:52];
      s1.v_frac = value_bits[51:0];
   end
endmodule

// File: hdl/dtfsn_round.sv
// ----------------------------------------------------------------------------
// dtfsn_round: binary64 to binary32 rounding
// Rounds the magnitude to nearest even and records exactness and direction.
// ----------------------------------------------------------------------------
module dtfsn_round
   import dtfsn_pkg::*;
(
   input  s1_type s1,
   output s2_type s2
);
   logic [53:0] sig;      // hidden bit + fraction + guard zero
   logic [11:0] sh;       // right shift for subnormal targets
   logic [7:0]  fexp;
   logic [23:0] keep;
   logic [53:0] shifted;
   logic        g, st, inc;
   logic [31:0] rm;

   always_comb begin
      sig  = {1'b1, s1.v_frac, 1'b0};
      fexp = 8'd0;
      sh   = 12'd0;
      // biased float exponent = e - 896; normal when e >= 897
      if (s1.v_exp >= 11'd897) begin
         fexp = 8'(s1.v_exp - 11'd896);
         sh   = 12'd0;
      end else begin
         fexp = 8'd0;
         sh   = 12'd897 - {1'b0, s1.v_exp};   // >= 1
      end
      if (sh > 12'd54) begin
         keep    = 24'd0;
         g       = 1'b0;
         st      = !s1.v_zero;
         shifted = 54'd0;
      end else begin
         shifted = sig >> sh[5:0];
         keep    = shifted[53:30];
         g       = shifted[29];
         st      = (shifted[28:0] != 29'd0) ||
                   ((sig & ((54'd1 << sh[5:0]) - 54'd1)) != 54'd0);
      end
      if (s1.v_zero) begin
         keep = 24'd0; g = 1'b0; st = 1'b0;
      end
      inc = g && (st || keep[0]);
      // normal: keep[23] is hidden; subnormal: keep[23] is 0 and fexp 0
      rm  = {1'b0, fexp, keep[22:0]} + {31'd0, inc};
      if (fexp == 8'd0 && keep[23])
         rm = {1'b0, 8'd1, keep[22:0]} + {31'd0, inc};
      s2.reject = s1.reject;
      s2.down   = s1.down;
      s2.sign   = s1.v_sign;
      s2.exact  = !(g || st);
      s2.rnd_up = inc;
      s2.mag    = rm[30:0];
   end
endmodule

// File: hdl/dtfsn_select.sv
// ----------------------------------------------------------------------------
// dtfsn_select: neighbor choice
// Keeps the rounded float when it lies on the target side, else steps it.
// ----------------------------------------------------------------------------
module dtfsn_select
   import dtfsn_pkg::*;
(
   input  s2_type      s2,
   output logic        found,
   output logic [31:0] float_bits
);
   logic        c_gt_v, c_lt_v, keep_c, up, away;
   logic [31:0] res;

   always_comb begin
      // signed relation of rounded float to value
      c_gt_v = !s2.exact && (s2.sign ? !s2.rnd_up : s2.rnd_up);
      c_lt_v = !s2.exact && !c_gt_v;
      keep_c = s2.down ? c_lt_v : c_gt_v;
      up     = !s2.down;
      away   = (up && !s2.sign) || (!up && s2.sign);
      res    = {s2.sign, s2.mag};
      if (!keep_c) begin
         if (s2.mag == 31'd0)
            res = {s2.down, 31'd1};
         else begin
            res  = away ? {s2.sign, s2.mag + 31'd1} : {s2.sign, s2.mag - 31'd1};
         end
      end
      found      = !s2.reject && (res[30:23] != 8'hFF);
      float_bits = found ? res : 32'd0;
   end
endmodule

// File: hdl/double_to_float_strict_neighbor_unit.sv
// ----------------------------------------------------------------------------
// double_to_float_strict_neighbor_unit: strict float neighbor of a double
// Registers: input, classify, round, select/output; an accepted req item
// passes them in order to rsp_valid, one item per cycle unless rsp stalls.
// One valid bit each; all advance when the output slot is free or taken.
// Synchronous active-high reset clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
module double_to_float_strict_neighbor_unit
   import dtfsn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_value_bits,
   input  logic [63:0] req_toward_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [31:0] rsp_float_bits
);
   logic        adv;
   logic        v0_ff, v1_ff, v2_ff, v3_ff;
   logic [63:0] a_ff, b_ff;
   s1_type      s1_in, s1_ff;
   s2_type      s2_in, s2_ff;
   logic        f_in, f_ff;
   logic [31:0] fb_in, fb_ff;

   // advance everything when the output slot is empty or being drained
   assign adv       = !v3_ff || rsp_ready;
   assign req_ready = adv;

   dtfsn_classify u_cls (.value_bits(a_ff), .toward_bits(b_ff), .s1(s1_in));
   dtfsn_round    u_rnd (.s1(s1_ff), .s2(s2_in));
   dtfsn_select   u_sel (.s2(s2_ff), .found(f_in), .float_bits(fb_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0; v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff  <= req_value_bits;
         b_ff  <= req_toward_bits;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         f_ff  <= f_in;
         fb_ff <= fb_in;
      end
   end

   assign rsp_valid      = v3_ff;
   assign rsp_found      = f_ff;
   assign rsp_float_bits = fb_ff;

   // a result that is not found carries zero bits
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_float_bits == 32'd0)
      else $error("not-found result with nonzero bits");
   // a stalled output holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_float_bits))
      else $error("output changed under stall");
   // an item in the round stage moves into the output stage when the pipe advances
   a_flow: assert property (@(posedge clock) disable iff (reset)
      adv && v2_ff |=> v3_ff)
      else $error("item lost between stages");
endmodule

// File: tb/tb_double_to_float_strict_neighbor_unit.sv
// ----------------------------------------------------------------------------
// tb_double_to_float_strict_neighbor_unit: self-checking bench for the unit
// Drives binary64 value/target pairs through the req channel with bursty
// gaps, predicts each binary32 strict neighbor with an integer rounding model
// and checks every rsp item in order, under random and long receiver stalls.
// ----------------------------------------------------------------------------
module tb_double_to_float_strict_neighbor_unit;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  RESET_CYCLES = 6;
   localparam int  CYCLE_LIMIT  = 400000;
   localparam int  RANDOM_ITEMS = 1200;
   localparam int  DRAIN_CYCLES = 12;
   localparam real FLOAT_MAX_R  = 340282346638528859811704183484516925440.0;

   // binary64 patterns used by the directed part
   localparam logic [63:0] D_POS_ZERO  = 64'h0000_0000_0000_0000;
   localparam logic [63:0] D_NEG_ZERO  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] D_ONE       = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] D_NEG_ONE   = 64'hBFF0_0000_0000_0000;
   localparam logic [63:0] D_TWO       = 64'h4000_0000_0000_0000;
   localparam logic [63:0] D_FLT_MAX   = 64'h47EF_FFFF_E000_0000;
   localparam logic [63:0] D_NEG_FMAX  = 64'hC7EF_FFFF_E000_0000;
   localparam logic [63:0] D_OVER_FMAX = 64'h47EF_FFFF_E000_0001;
   localparam logic [63:0] D_POS_INF   = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] D_NEG_INF   = 64'hFFF0_0000_0000_0000;
   localparam logic [63:0] D_QNAN      = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] D_FLT_TRUE_MIN = 64'h36A0_0000_0000_0000;
   localparam logic [63:0] D_HALF_TMIN = 64'h3690_0000_0000_0000;
   localparam logic [63:0] D_TINY      = 64'h0000_0000_0000_0001;
   localparam logic [63:0] D_NEG_TINY  = 64'h8000_0000_0000_0001;
   localparam logic [63:0] D_TIE_EVEN  = 64'h3FF0_0000_1000_0000;
   localparam logic [63:0] D_TIE_ODD   = 64'h3FF0_0000_3000_0000;
   localparam logic [63:0] D_DBL_MAX   = 64'h7FEF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic        found;
      logic [31:0] bits;
   } neighbor_type;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts the neighbor for each accepted item and checks rsp
   // -------------------------------------------------------------------------
   class neighbor_scoreboard;
      neighbor_type expected_neighbors[$];
      int           mismatches;
      int           checked;

      function bit is_nan(logic [63:0] b);
         return b[62:52] == 11'h7FF && b[51:0] != 52'd0;
      endfunction

      function neighbor_type predict_neighbor(logic [63:0] vb, logic [63:0] tb);
         neighbor_type res;
         real         rv, rt;
         int          unb_exp, sh;
         logic [63:0] q, rem, half;
         logic [30:0] mag;
         logic        sgn, exact, rnd_up, down, on_side;
         logic [31:0] c, r;
         res = '0;
         if (is_nan(vb) || is_nan(tb)) return res;
         rv = $bitstoreal(vb);
         rt = $bitstoreal(tb);
         if (rv > FLOAT_MAX_R || rv < -FLOAT_MAX_R) return res;
         if (rv == rt) return res;
         sgn = vb[63];
         if (vb[62:0] == 63'd0) begin
            mag = '0; exact = 1'b1; rnd_up = 1'b0;
         end else if (vb[62:52] == 11'd0) begin
            // double subnormals lie far below half the smallest float
            mag = '0; exact = 1'b0; rnd_up = 1'b0;
         end else begin
            unb_exp = int'(vb[62:52]) - 1023;
            if (unb_exp >= -126) begin
               q    = (64'(unb_exp + 127) << 23) | 64'(vb[51:29]);
               rem  = 64'(vb[28:0]);
               half = 64'h1000_0000;
            end else begin
               // float subnormal: scale mantissa to units of 2^-149
               sh = -97 - unb_exp;
               if (sh > 63) sh = 63;
               q    = {11'd0, 1'b1, vb[51:0]} >> sh;
               rem  = {11'd0, 1'b1, vb[51:0]} & ((64'd1 << sh) - 64'd1);
               half = 64'd1 << (sh - 1);
            end
            rnd_up = rem > half || (rem == half && q[0]);
            mag    = 31'(q + 64'(rnd_up));
            exact  = rem == 64'd0;
         end
         c       = {sgn, mag};
         down    = rt < rv;
         on_side = !exact && (down ? !(rnd_up ^ sgn) : (rnd_up ^ sgn));
         if (on_side) r = c;
         else if (mag == 31'd0) r = down ? 32'h8000_0001 : 32'h0000_0001;
         else if (!sgn) r = down ? c - 32'd1 : c + 32'd1;
         else r = down ? c + 32'd1 : c - 32'd1;
         if (r[30:0] >= 31'h7F80_0000) return res;
         res.found = 1'b1;
         res.bits  = r;
         return res;
      endfunction

      function void note_request(logic [63:0] vb, logic [63:0] tb);
         expected_neighbors.push_back(predict_neighbor(vb, tb));
      endfunction

      function void check_response(logic found, logic [31:0] bits);
         neighbor_type exp_n;
         checked++;
         if (expected_neighbors.size() == 0) begin
            $display("%0t: unexpected rsp item found=%0d bits=%h", $realtime, found, bits);
            mismatches++;
            return;
         end
         exp_n = expected_neighbors.pop_front();
         if (found !== exp_n.found) begin
            $display("%0t: found mismatch expected %0d actual %0d",
                     $realtime, exp_n.found, found);
            mismatches++;
         end
         if (bits !== exp_n.bits) begin
            $display("%0t: float_bits mismatch expected %h actual %h",
                     $realtime, exp_n.bits, bits);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_value_bits = '0;
   logic [63:0] req_toward_bits = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_found;
   logic [31:0] rsp_float_bits;

   neighbor_scoreboard sb = new();
   int          cycle_count = 0;
   int          found_count = 0;

   always #2 clock = ~clock;

   double_to_float_strict_neighbor_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value_bits (req_value_bits),
      .req_toward_bits(req_toward_bits),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_float_bits (rsp_float_bits)
   );

   // Watchdog: fail and end the run once the cycle count passes CYCLE_LIMIT
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Receiver: random stall pattern, plus one long hold-off so the pipe
   // fills and back-pressures the req side.
   int stall_left = 0;
   int ready_pct  = 70;
   int rx_cycles  = 0;
   always @(posedge clock) begin
      rx_cycles++;
      if (rx_cycles >= 300 && rx_cycles < 500) begin
         rsp_ready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_left = $urandom_range(5, 60);
            case ($urandom_range(0, 3))
               0: ready_pct = 100;
               1: ready_pct = 20;
               default: ready_pct = $urandom_range(40, 90);
            endcase
         end
         stall_left--;
         rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
      end
   end

   // Sample at the falling edge: inputs only move at the rising edge, so
   // valid/ready seen here are the ones the next rising edge will use.
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_found) found_count++;
         sb.check_response(rsp_found, rsp_float_bits);
      end
   end

   // Offer one item and hold it until accepted; returns at a rising edge.
   task automatic send_pair(input logic [63:0] vb, input logic [63:0] tb);
      bit taken;
      req_valid       <= 1'b1;
      req_value_bits  <= vb;
      req_toward_bits <= tb;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      sb.note_request(vb, tb);
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Random binary64 pattern biased toward interesting float regions
   function automatic logic [63:0] rand_double();
      logic [63:0] d;
      d = {$urandom(), $urandom()};
      case ($urandom_range(0, 9))
         0, 1: ;  // raw pattern, covers every bit
         2, 3: d[62:52] = 11'($urandom_range(1023 - 152, 1023 + 128));
         4: begin  // exactly representable float
            d[62:52] = 11'($urandom_range(1023 - 126, 1023 + 127));
            d[28:0]  = '0;
         end
         5: begin  // halfway between two floats
            d[62:52] = 11'($urandom_range(1023 - 126, 1023 + 127));
            d[28:0]  = 29'h1000_0000;
         end
         6: d[62:52] = 11'($urandom_range(1023 - 150, 1023 - 126));
         7: d[62:0] = 63'(D_FLT_MAX) + 63'($urandom_range(0, 4)) - 63'h2000_0000;
         8: d[62:52] = 11'h000;
         default: begin
            case ($urandom_range(0, 4))
               0: d = D_POS_ZERO;
               1: d = D_POS_INF;
               2: d = D_QNAN | 64'($urandom());
               3: d = D_FLT_TRUE_MIN;
               default: d = D_HALF_TMIN;
            endcase
            d[63] = 1'($urandom_range(0, 1));
         end
      endcase
      return d;
   endfunction

   task automatic run_directed();
      send_pair(D_POS_ZERO, D_NEG_ZERO);      // equal operands through signed zero
      send_pair(D_ONE, D_ONE);                // equal operands
      send_pair(D_ONE, D_TWO);
      send_pair(D_ONE, D_POS_ZERO);
      send_pair(D_NEG_ONE, D_NEG_INF);
      send_pair(D_FLT_MAX, D_POS_INF);        // step would overflow to infinity
      send_pair(D_FLT_MAX, D_POS_ZERO);
      send_pair(D_NEG_FMAX, D_NEG_INF);
      send_pair(D_OVER_FMAX, D_POS_ZERO);     // just beyond the largest float
      send_pair(D_POS_INF, D_POS_ZERO);
      send_pair(D_DBL_MAX, D_NEG_INF);
      send_pair(D_QNAN, D_POS_ZERO);          // NaN value
      send_pair(D_ONE, D_QNAN);               // NaN target
      send_pair(D_POS_ZERO, D_ONE);           // zero steps to smallest subnormal
      send_pair(D_POS_ZERO, D_NEG_ONE);
      send_pair(D_NEG_ZERO, D_ONE);
      send_pair(D_NEG_TINY, D_ONE);           // tiny negative up gives -0
      send_pair(D_TINY, D_NEG_ONE);           // tiny positive down gives +0
      send_pair(D_TINY, D_ONE);
      send_pair(D_HALF_TMIN, D_ONE);
      send_pair(D_HALF_TMIN, D_NEG_ZERO);
      send_pair(D_TIE_EVEN, D_TWO);           // ties to even
      send_pair(D_TIE_ODD, D_POS_ZERO);
      send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_pair(D_FLT_TRUE_MIN, D_NEG_ONE);
   endtask

   task automatic run_random();
      int          burst;
      int          sent;
      logic [63:0] vb, tb;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            vb = rand_double();
            case ($urandom_range(0, 15))
               0: tb = vb;                          // equal operands
               1: tb = {vb[63] ^ 1'b1, vb[62:0]};   // mirrored
               2: tb = {$urandom_range(0, 1) ? D_NEG_INF[63] : 1'b0, D_POS_INF[62:0]};
               3: tb = vb + 64'd1;
               4: tb = vb - 64'd1;
               default: tb = rand_double();
            endcase
            send_pair(vb, tb);
            sent++;
         end
         idle_cycles(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7));
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      idle_cycles(3);
      run_random();
      // Drain: wait for every predicted item, then let the pipe settle
      while (sb.expected_neighbors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d rsp items (%0d with a neighbor found), including",
               sb.checked, found_count);
      $display("signed zeros, subnormals, ties, overflow, NaN and equal operands.");
      if (sb.mismatches == 0 && sb.expected_neighbors.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/dtfsn_pkg.sv
hdl/dtfsn_classify.sv
hdl/dtfsn_round.sv
hdl/dtfsn_select.sv
hdl/double_to_float_strict_neighbor_unit.sv
tb/tb_double_to_float_strict_neighbor_unit.sv
